// File: hw/rtl/fat12w_pkg.sv
// Shared types and constants for the FAT12 cluster chain walker.
`default_nettype none
package fat12w_pkg;

	// Default sizes
	localparam int unsigned TABLE_BYTES_DEF = 8192;
	localparam int unsigned MAX_CHAIN_DEF   = 64;

	// Field widths
	localparam int unsigned BIDX_W  = 13;
	localparam int unsigned CLUS_W  = 12;
	localparam int unsigned SIZE_W  = 14;
	localparam int unsigned STAT_W  = 2;

	// Table size register reset value
	localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd4608;

	// FAT12 entry codes
	localparam logic [CLUS_W-1:0] END_MARK     = 12'hFF8;
	localparam logic [CLUS_W-1:0] ENTRY_MASK   = 12'h0FFF;
	localparam logic [CLUS_W-1:0] OUT_OF_TABLE = 12'hFFF;
	localparam logic [CLUS_W-1:0] FREE_ENTRY   = 12'h000;

	// Item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_WALK = 1'b1;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_CHAIN    = 2'd0,
		ST_NO_CHAIN = 2'd1,
		ST_CUT      = 2'd2
	} status_t;

	// Walker sequencer states
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RLO  = 5'b00010,
		S_RHI  = 5'b00100,
		S_ENT  = 5'b01000,
		S_DEC  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/fat12w_table_mem.sv
// Byte store holding the FAT12 table: one write port, one registered read port.
`default_nettype none
module fat12w_table_mem
	import fat12w_pkg::*;
#(
	parameter int unsigned DEPTH = TABLE_BYTES_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [BIDX_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic [BIDX_W-1:0] raddr,
	output logic      [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	// Writes beyond the store are dropped
	logic wr_in_range;
	assign wr_in_range = (32'(waddr) < DEPTH);

	always_ff @(posedge clk) begin
		if (we && wr_in_range) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr[AW-1:0]];
	end

endmodule
`default_nettype wire

// File: hw/rtl/fat12_cluster_chain_walker_top.sv
// Top level of the FAT12 cluster chain walker.
`default_nettype none
// A load item (action 0) writes one table byte and gives no result; a
// byte_index at or above TABLE_BYTES is dropped. A walk item (action 1) emits
// the start cluster and then follows the packed 12-bit entries until a free or
// end-of-chain entry, a read past the configured table size, or MAX_CHAIN
// results (the last then carries status 2). Each cluster goes through the
// states read low byte, read high byte, assemble entry and decide, because the
// table has a single read port; a cluster whose entry lies outside the table
// goes from the low-byte read straight to the decision. A full output register
// holds the walk in the decide state. A start at or above 0xFF8, or a table
// under 3 bytes, gives one no-chain result. The next item is taken while the
// final result still waits in the output register. Table bytes read before
// being loaded return arbitrary data.
module fat12_cluster_chain_walker_top
	import fat12w_pkg::*;
#(
	parameter int unsigned TABLE_BYTES = TABLE_BYTES_DEF,
	parameter int unsigned MAX_CHAIN   = MAX_CHAIN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data,
	// input items
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              action,
	input  wire logic [BIDX_W-1:0] byte_index,
	input  wire logic [7:0]        byte_value,
	input  wire logic [CLUS_W-1:0] start_cluster,
	// result items
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CLUS_W-1:0]      cluster,
	output logic [STAT_W-1:0]      status,
	output logic                   last
);

	localparam int unsigned CNT_W = $clog2(MAX_CHAIN + 1);
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(TABLE_BYTES);
	localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_CHAIN - 1);

	state_t              state_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CLUS_W-1:0]   clus_q;
	logic [CLUS_W-1:0]   entry_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                nochain_q;
	logic [7:0]          lo_q;
	logic                out_valid_q;
	logic [CLUS_W-1:0]   out_clus_q;
	status_t             out_stat_q;
	logic                out_last_q;

	// Config register is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	// Effective table size, clamped to the store
	logic [SIZE_W-1:0] size_eff;
	assign size_eff = (size_q > SIZE_MAX) ? SIZE_MAX : size_q;

	// Input transfer
	logic in_xfer;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// Entry byte offset: clus*3/2
	logic [BIDX_W-1:0] off;
	logic [BIDX_W-1:0] off_p1;
	logic              oob;
	assign off    = BIDX_W'(clus_q) + BIDX_W'(clus_q >> 1);
	assign off_p1 = off + BIDX_W'(1);
	assign oob    = ({1'b0, off_p1} >= size_eff);

	// Table store
	logic [BIDX_W-1:0] raddr;
	logic [7:0]        rdata;
	assign raddr = (state_q == S_RHI) ? off_p1 : off;

	fat12w_table_mem #(
		.DEPTH (TABLE_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (in_xfer && (action == ACT_LOAD)),
		.waddr (byte_index),
		.wdata (byte_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Unpack the 12-bit entry from the byte pair
	logic [CLUS_W-1:0] entry_rd;
	assign entry_rd = clus_q[0] ? {rdata, lo_q[7:4]} & ENTRY_MASK
	                            : {rdata[3:0], lo_q} & ENTRY_MASK;

	// Output register can take a new result
	logic out_free;
	logic out_load;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_DEC) && out_free;

	// Result decision
	logic    end_entry;
	logic    dec_last;
	status_t dec_stat;
	assign end_entry = (entry_q == FREE_ENTRY) || (entry_q >= END_MARK);

	always_comb begin
		if (nochain_q) begin
			dec_stat = ST_NO_CHAIN;
			dec_last = 1'b1;
		end else if (end_entry) begin
			dec_stat = ST_CHAIN;
			dec_last = 1'b1;
		end else if (cnt_q == CNT_LAST) begin
			dec_stat = ST_CUT;
			dec_last = 1'b1;
		end else begin
			dec_stat = ST_CHAIN;
			dec_last = 1'b0;
		end
	end

	// Walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nochain_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && (action == ACT_WALK)) begin
						cnt_q <= '0;
						if ((size_eff < SIZE_W'(3)) || (start_cluster >= END_MARK)) begin
							nochain_q <= 1'b1;
							state_q   <= S_DEC;
						end else begin
							nochain_q <= 1'b0;
							state_q   <= S_RLO;
						end
					end
				end
				S_RLO: begin
					state_q <= oob ? S_DEC : S_RHI;
				end
				S_RHI: begin
					state_q <= S_ENT;
				end
				S_ENT: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (out_free) begin
						if (dec_last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_RLO;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Walk datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer && (action == ACT_WALK)) begin
			clus_q <= start_cluster;
		end else if (out_load && !dec_last) begin
			clus_q <= entry_q;
		end
		if (state_q == S_RLO && oob) begin
			entry_q <= OUT_OF_TABLE;
		end else if (state_q == S_ENT) begin
			entry_q <= entry_rd;
		end
		if (state_q == S_RHI) begin
			lo_q <= rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_clus_q <= nochain_q ? FREE_ENTRY : clus_q;
			out_stat_q <= dec_stat;
			out_last_q <= dec_last;
		end
	end

	assign out_valid = out_valid_q;
	assign cluster   = out_clus_q;
	assign status    = out_stat_q;
	assign last      = out_last_q;

endmodule
`default_nettype wire

// File: test/fat12_cluster_chain_walker_checker.sv
// Checker for the FAT12 chain walker: mirrors the table, predicts walk results, compares them.
module fat12_cluster_chain_walker_checker
	import fat12w_pkg::*;
#(
	parameter int unsigned TABLE_BYTES = TABLE_BYTES_DEF,
	parameter int unsigned MAX_CHAIN   = MAX_CHAIN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              action,
	input  logic [BIDX_W-1:0] byte_index,
	input  logic [7:0]        byte_value,
	input  logic [CLUS_W-1:0] start_cluster,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [CLUS_W-1:0] cluster,
	input  logic [STAT_W-1:0] status,
	input  logic              last,
	output int                error_count,
	output int                pending,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// one expected result
	typedef struct packed {
		logic [CLUS_W-1:0] clus;
		status_t           st;
		logic              fin;
	} link_t;

	link_t             expected_links[$];
	logic [7:0]        fat_mirror [TABLE_BYTES];
	logic [SIZE_W-1:0] table_size;
	logic [CLUS_W-1:0] walk_cursor;
	logic [6:0]        walk_count;

	// packed 12-bit entry of a cluster; reads past the table end the chain
	function automatic logic [CLUS_W-1:0] entry_at(input logic [CLUS_W-1:0] c,
			input int unsigned lim);
		int unsigned off;
		logic [7:0]  lo;
		logic [7:0]  hi;
		off = c * 3 / 2;
		if (off + 1 >= lim)
			return OUT_OF_TABLE;
		lo = fat_mirror[off];
		hi = fat_mirror[off + 1];
		if (c[0])
			return {hi, lo[7:4]};
		return {hi[3:0], lo};
	endfunction

	// expand one walk into its expected results
	task automatic predict_walk(input logic [CLUS_W-1:0] start);
		int unsigned       lim;
		logic [CLUS_W-1:0] c;
		logic [CLUS_W-1:0] nxt;
		int                n;
		lim = (table_size > TABLE_BYTES) ? TABLE_BYTES : table_size;
		if (lim < 3 || start >= END_MARK) begin
			expected_links.push_back('{clus: '0, st: ST_NO_CHAIN, fin: 1'b1});
			walk_count = 7'd1;
			return;
		end
		c = start;
		n = 0;
		forever begin
			walk_cursor = c;
			nxt = entry_at(c, lim);
			n++;
			if (nxt == FREE_ENTRY || nxt >= END_MARK) begin
				expected_links.push_back('{clus: c, st: ST_CHAIN, fin: 1'b1});
				break;
			end
			if (n >= MAX_CHAIN) begin
				expected_links.push_back('{clus: c, st: ST_CUT, fin: 1'b1});
				break;
			end
			expected_links.push_back('{clus: c, st: ST_CHAIN, fin: 1'b0});
			c = nxt;
		end
		walk_count = 7'(n);
	endtask

	task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		error_count++;
	endtask

	// results first (they belong to earlier walks), then config and new items
	always @(posedge clk or negedge arst_n) begin
		link_t head;
		if (!arst_n) begin
			table_size = SIZE_RESET;
			walk_cursor = '0;
			walk_count = '0;
			expected_links.delete();
			error_count = 0;
			results_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_links.size() == 0) begin
					$display("%0t: unexpected result, expected none, got cluster %0d status %0d last %0d",
						$time, cluster, status, last);
					error_count++;
				end else begin
					head = expected_links.pop_front();
					if (cluster !== head.clus)
						report("cluster", head.clus, cluster);
					if (status !== head.st)
						report("status", head.st, status);
					if (last !== head.fin)
						report("last", head.fin, last);
					results_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				table_size = cfg_data;
			if (in_valid && in_ready) begin
				if (action == ACT_LOAD) begin
					if (byte_index < TABLE_BYTES)
						fat_mirror[byte_index] = byte_value;
				end else begin
					predict_walk(start_cluster);
				end
			end
		end
		pending = expected_links.size();
	end

endmodule

// File: test/fat12_cluster_chain_walker_top_tb.sv
// Testbench top for the FAT12 chain walker: clock, reset, stimulus and verdict.
module fat12_cluster_chain_walker_top_tb
	import fat12w_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FAT_BYTES   = TABLE_BYTES_DEF;
	localparam int unsigned CHAIN_CAP   = MAX_CHAIN_DEF;
	localparam int          HOLD_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              action = ACT_LOAD;
	logic [BIDX_W-1:0] byte_index = '0;
	logic [7:0]        byte_value = '0;
	logic [CLUS_W-1:0] start_cluster = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CLUS_W-1:0] cluster;
	logic [STAT_W-1:0] status;
	logic              last;

	int error_count;
	int pending;
	int results_checked;

	// stimulus knobs and counters
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_req = 1'b0;
	bit   hold_done = 1'b0;
	int   hold_count;
	int   items_sent = 0;
	int   loads_sent = 0;
	int   walks_sent = 0;

	// what the stimulus has written so far, to keep walks on loaded bytes
	logic [7:0]  shadow_bytes [FAT_BYTES];
	bit          shadow_valid [FAT_BYTES];
	int unsigned shadow_lim = SIZE_RESET;

	fat12_cluster_chain_walker_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.byte_index   (byte_index),
		.byte_value   (byte_value),
		.start_cluster(start_cluster),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cluster      (cluster),
		.status       (status),
		.last         (last)
	);

	fat12_cluster_chain_walker_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.byte_index     (byte_index),
		.byte_value     (byte_value),
		.start_cluster  (start_cluster),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cluster        (cluster),
		.status         (status),
		.last           (last),
		.error_count    (error_count),
		.pending        (pending),
		.results_checked(results_checked)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, plus one long hold-off when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one input transfer; starts and ends at a falling edge, valid stays up for the next item
	task automatic send_item(input logic act, input logic [BIDX_W-1:0] idx,
			input logic [7:0] val, input logic [CLUS_W-1:0] start);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		byte_index <= idx;
		byte_value <= val;
		start_cluster <= start;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_byte(input logic [BIDX_W-1:0] idx, input logic [7:0] val);
		send_item(ACT_LOAD, idx, val, CLUS_W'($urandom));
		shadow_bytes[idx] = val;
		shadow_valid[idx] = 1'b1;
		loads_sent++;
	endtask

	// write a 12-bit entry, keeping the neighbor's nibble of a shared byte
	task automatic set_entry(input logic [CLUS_W-1:0] c, input logic [CLUS_W-1:0] e);
		int unsigned off;
		logic [7:0]  b0;
		logic [7:0]  b1;
		off = c * 3 / 2;
		b0 = shadow_valid[off] ? shadow_bytes[off] : 8'($urandom);
		b1 = shadow_valid[off + 1] ? shadow_bytes[off + 1] : 8'($urandom);
		if (c[0]) begin
			b0[7:4] = e[3:0];
			b1 = e[11:4];
		end else begin
			b0 = e[7:0];
			b1[3:0] = e[11:8];
		end
		load_byte(BIDX_W'(off), b0);
		load_byte(BIDX_W'(off + 1), b1);
	endtask

	// true when following the chain touches only loaded bytes
	function automatic bit chain_safe(input logic [CLUS_W-1:0] start);
		logic [CLUS_W-1:0] c;
		int unsigned       off;
		logic [7:0]        lo;
		logic [7:0]        hi;
		if (shadow_lim < 3 || start >= END_MARK)
			return 1'b1;
		c = start;
		for (int k = 0; k < CHAIN_CAP; k++) begin
			off = c * 3 / 2;
			if (off + 1 >= shadow_lim)
				return 1'b1;
			if (!shadow_valid[off] || !shadow_valid[off + 1])
				return 1'b0;
			lo = shadow_bytes[off];
			hi = shadow_bytes[off + 1];
			c = c[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
			if (c == FREE_ENTRY || c >= END_MARK)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// walks that would reach unloaded bytes become end-marker starts
	task automatic walk(input logic [CLUS_W-1:0] start);
		logic [CLUS_W-1:0] s;
		s = chain_safe(start) ? start : END_MARK + CLUS_W'($urandom_range(7));
		send_item(ACT_WALK, BIDX_W'($urandom), 8'($urandom), s);
		walks_sent++;
	endtask

	// stop offering items and wait for every expected result plus load settling
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register write; only called with the block idle
	task automatic set_table_size(input logic [SIZE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		shadow_lim = (v > FAT_BYTES) ? FAT_BYTES : v;
	endtask

	// random linked chain: ends on a free entry or end marker, or loops back (length cap)
	task automatic build_chain(input int len, input bit looped);
		logic [CLUS_W-1:0] links[$];
		int unsigned       top_clus;
		logic [CLUS_W-1:0] term;
		top_clus = (shadow_lim >= 5) ? (shadow_lim - 2) * 2 / 3 : 2;
		if (top_clus > 12'hFF7)
			top_clus = 12'hFF7;
		if (top_clus < 2)
			top_clus = 2;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(7) == 0)
				links.push_back(CLUS_W'($urandom_range(12'hFF7, 2)));
			else
				links.push_back(CLUS_W'($urandom_range(top_clus, 2)));
		end
		for (int k = 0; k < len - 1; k++)
			set_entry(links[k], links[k + 1]);
		if (looped)
			term = links[$urandom_range(len - 1)];
		else if ($urandom_range(3) == 0)
			term = FREE_ENTRY;
		else
			term = END_MARK + CLUS_W'($urandom_range(7));
		set_entry(links[len - 1], term);
		walk(links[0]);
		if ($urandom_range(2) == 0)
			walk(links[$urandom_range(len - 1)]);
	endtask

	// random traffic: mostly well-formed chains, some stray loads and walks
	task automatic run_phase(input int n_items, input int idle, input int stall);
		int first;
		int pick;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70)
				build_chain(($urandom_range(9) == 0) ? $urandom_range(40, 20)
					: $urandom_range(8, 1), $urandom_range(4) == 0);
			else if (pick < 85)
				load_byte(BIDX_W'($urandom), 8'($urandom));
			else
				walk(CLUS_W'($urandom));
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: chain shapes and start extremes at the default size
		set_table_size(SIZE_RESET);
		set_entry(12'd0, 12'hFF7);       // next lies past the table
		walk(12'd0);
		set_entry(12'd2, 12'd3);
		set_entry(12'd3, OUT_OF_TABLE);
		walk(12'd2);
		set_entry(12'd4, FREE_ENTRY);    // free entry ends at once
		walk(12'd4);
		set_entry(12'd5, 12'd5);         // self loop hits the length cap
		walk(12'd5);
		set_entry(12'd1, END_MARK);
		walk(12'd1);
		walk(END_MARK);                  // end-marker starts
		walk(12'hFFF);
		walk(12'hFF7);
		load_byte(13'd8191, 8'hFF);
		load_byte(13'd8190, 8'h00);
		drain();

		// tiny, empty and oversized tables
		set_table_size(14'd2);
		walk(12'd2);
		drain();
		set_table_size(14'd0);
		walk(12'd0);
		drain();
		set_table_size(14'd3);
		walk(12'd0);
		walk(12'd1);
		drain();
		set_table_size(14'h3FFF);
		walk(12'd2);
		walk(12'd5);
		drain();

		// random phases; the first one carries the long output hold-off
		hold_req <= 1'b1;
		run_phase(70, 0, 0);
		set_table_size(14'd8192);
		run_phase(70, 87, 0);
		set_table_size(14'($urandom_range(8192, 64)));
		run_phase(70, 0, 87);
		set_table_size(14'd1500);
		run_phase(70, 28, 28);

		repeat (20) @(negedge clk);
		$display("Ran %0d items (%0d byte loads, %0d walks) over table sizes 0 to 16383",
			items_sent, loads_sent, walks_sent);
		$display("and four idle/stall mixes; %0d results compared, %0d mismatches",
			results_checked, error_count);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);
		if (error_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: fat12_cluster_chain_walker_top.f
hw/rtl/fat12w_pkg.sv
hw/rtl/fat12w_table_mem.sv
hw/rtl/fat12_cluster_chain_walker_top.sv
test/fat12_cluster_chain_walker_checker.sv
test/fat12_cluster_chain_walker_top_tb.sv
